>>> src/clf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clf_pkg;

    // Frame limits
    localparam int MAX_FRAME   = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = 7;
    localparam int BYTE_W      = 8;

    // Characters and arithmetic constants
    localparam logic [7:0] CHAR_NEWLINE  = 8'd10;
    localparam logic [7:0] CHAR_SEMI     = 8'd59;
    localparam logic [7:0] CHAR_ZERO     = 8'd48;
    localparam logic [7:0] CHAR_SPACE    = 8'd32;
    localparam logic [7:0] CHAR_MAXVIS   = 8'd127;
    localparam logic [7:0] CHECK_MOD     = 8'd99;
    localparam logic [7:0] CONFIRM_RESET = 8'd33;

    // Output byte source select
    localparam logic [2:0] OSEL_TL   = 3'd0;
    localparam logic [2:0] OSEL_SEMI = 3'd1;
    localparam logic [2:0] OSEL_TENS = 3'd2;
    localparam logic [2:0] OSEL_ONES = 3'd3;
    localparam logic [2:0] OSEL_CONF = 3'd4;
    localparam logic [2:0] OSEL_PAY  = 3'd5;
    localparam logic [2:0] OSEL_NL   = 3'd6;

    // Controller to datapath commands
    typedef struct packed {
        logic       in_take;
        logic       calc_check;
        logic       calc_digits;
        logic       load_out;
        logic [2:0] out_sel;
        logic       out_last;
        logic       idx_inc;
        logic       clr_msg;
    } t_clf_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic too_long;
        logic add_nl;
        logic conf_zero;
        logic idx_at_end;
        logic out_free;
    } t_clf_stat;

endpackage

`default_nettype wire

>>> src/checksummed_line_framer.sv
// After the last byte is taken, S_CHECK computes the check value and S_DIGIT its digits.
// Bytes are taken one per cycle; up to four prefix items go out one per cycle while the
// output is free, and each payload byte passes a store read, then the output register.
// No new byte is taken until the last item of a frame is loaded.
// Reset is synchronous, active low: clears counts, flags and output valid, confirm to 33.
`timescale 1ns / 1ps
`default_nettype none

module checksummed_line_framer
    import clf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Payload in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
    input  wire logic        s_axis_tlast,   // payload_last
    // Frame out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] frame_byte
    output logic             m_axis_tlast,   // frame_last
    output logic             m_axis_tuser,   // [0] too_long
    // Register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [2:0] ADDR_CONFIRM = 3'd0;

    logic [7:0] r_confirm;
    t_clf_cmd   cmd;
    t_clf_stat  stat;

    // Confirm character register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm <= CONFIRM_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_CONFIRM) begin
            r_confirm <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CONFIRM) ? {24'd0, r_confirm} : 32'd0;

    clf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    clf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_byte   (s_axis_tdata),
        .i_confirm   (r_confirm),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_tl    (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // A rejected message is a single zero item that closes the message
    a_tl_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
        else $error("too_long item is not a closing zero byte");

    // The byte that ends a message stops intake for the frame build
    a_stop_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("intake still open after end of message");

    // No frame item goes out while bytes are being collected from an idle output
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tready && !m_axis_tvalid) |=> (!m_axis_tvalid || !$past(s_axis_tready)
            || $past(s_axis_tvalid && s_axis_tlast)) || !s_axis_tready)
        else $error("frame item appeared during collection");
`endif

endmodule

`default_nettype wire

>>> src/clf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module clf_datapath
    import clf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_clf_cmd          i_cmd,
    output t_clf_stat              o_stat,
    input  wire logic [BYTE_W-1:0] i_in_byte,
    input  wire logic [BYTE_W-1:0] i_confirm,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic                   o_out_last,
    output logic                   o_out_tl
);

    // Add a byte to a residue mod 99, counting printable ASCII only
    function automatic logic [6:0] mod_add(input logic [6:0] acc, input logic [7:0] b);
        logic [7:0] red;
        logic [7:0] t;
        red = (b >= CHECK_MOD) ? (b - CHECK_MOD) : b;
        if (!(b >= CHAR_SPACE && b <= CHAR_MAXVIS)) begin
            red = 8'd0;
        end
        t = {1'b0, acc} + red;
        if (t >= CHECK_MOD) begin
            t = t - CHECK_MOD;
        end
        return t[6:0];
    endfunction

    logic [BYTE_W-1:0]  r_store [STORE_DEPTH];
    logic [BYTE_W-1:0]  r_rdata;
    logic [COUNT_W-1:0] r_count;
    logic               r_ovf;
    logic [6:0]         r_psum;
    logic               r_stop;
    logic [BYTE_W-1:0]  r_last_byte;
    logic [ADDR_W-1:0]  r_idx;
    logic [6:0]         r_check;
    logic [3:0]         r_tens;
    logic [3:0]         r_ones;
    logic               r_too_long;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_last;
    logic               r_out_tl;

    logic               store_ok;
    logic [7:0]         len_plus;
    logic [14:0]        tens_prod;
    logic [3:0]         tens_val;
    logic [6:0]         tens_x10;
    logic [BYTE_W-1:0]  out_byte_sel;
    logic [COUNT_W-1:0] count_m1;

    assign store_ok  = (r_count < COUNT_W'(MAX_FRAME));
    assign len_plus  = {1'b0, r_count} + 8'd5;
    assign count_m1  = r_count - COUNT_W'(1);
    // Divide by ten through a reciprocal, exact for values below 180
    assign tens_prod = {8'd0, r_check} * 15'd205;
    assign tens_val  = tens_prod[14:11];
    assign tens_x10  = {tens_val, 3'b000} + {2'b00, tens_val, 1'b0};

    // Payload store: write on accept, read the emit index every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take && store_ok) begin
            r_store[r_count[ADDR_W-1:0]] <= i_in_byte;
        end
        r_rdata <= r_store[r_idx];
    end

    // Message bookkeeping: count, overflow, running check residue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_msg) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_psum  <= '0;
            r_stop  <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.in_take) begin
                if (store_ok) begin
                    r_count     <= r_count + COUNT_W'(1);
                    r_last_byte <= i_in_byte;
                    if (!r_stop) begin
                        r_psum <= mod_add(r_psum, i_in_byte);
                        if (i_in_byte == CHAR_NEWLINE) begin
                            r_stop <= 1'b1;
                        end
                    end
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + ADDR_W'(1);
            end
        end
    end

    // Check value and its two decimal digits
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_check) begin
            r_too_long <= r_ovf || (len_plus >= 8'(MAX_FRAME));
            if (i_confirm == 8'd0 || i_confirm == CHAR_NEWLINE) begin
                r_check <= 7'd1;
            end else begin
                r_check <= mod_add(r_psum, i_confirm) + 7'd1;
            end
        end
        if (i_cmd.calc_digits) begin
            r_tens <= tens_val;
            r_ones <= 4'(r_check - tens_x10);
        end
    end

    // Pick the frame byte to send
    always_comb begin
        case (i_cmd.out_sel)
            OSEL_TL:   out_byte_sel = 8'd0;
            OSEL_SEMI: out_byte_sel = CHAR_SEMI;
            OSEL_TENS: out_byte_sel = CHAR_ZERO + {4'd0, r_tens};
            OSEL_ONES: out_byte_sel = CHAR_ZERO + {4'd0, r_ones};
            OSEL_CONF: out_byte_sel = i_confirm;
            OSEL_PAY:  out_byte_sel = r_rdata;
            OSEL_NL:   out_byte_sel = CHAR_NEWLINE;
            default:   out_byte_sel = 8'd0;
        endcase
    end

    // Output register: load a new item or drop the one taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_byte <= out_byte_sel;
            r_out_last <= i_cmd.out_last;
            r_out_tl   <= (i_cmd.out_sel == OSEL_TL);
        end
    end

    assign o_stat.too_long   = r_too_long;
    assign o_stat.add_nl     = (r_last_byte != CHAR_NEWLINE);
    assign o_stat.conf_zero  = (i_confirm == 8'd0);
    assign o_stat.idx_at_end = ({1'b0, r_idx} == count_m1);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_tl    = r_out_tl;

endmodule

`default_nettype wire

>>> src/clf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module clf_ctrl
    import clf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_last,
    output logic           o_in_ready,
    input  wire t_clf_stat i_stat,
    output t_clf_cmd       o_cmd
);

    localparam logic [3:0] S_COLLECT = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_DIGIT   = 4'd2;
    localparam logic [3:0] S_TL      = 4'd3;
    localparam logic [3:0] S_SEMI    = 4'd4;
    localparam logic [3:0] S_TENS    = 4'd5;
    localparam logic [3:0] S_ONES    = 4'd6;
    localparam logic [3:0] S_CONF    = 4'd7;
    localparam logic [3:0] S_RD      = 4'd8;
    localparam logic [3:0] S_PAY     = 4'd9;
    localparam logic [3:0] S_NL      = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       take;

    assign o_in_ready = (r_state == S_COLLECT);
    assign take       = o_in_ready && i_in_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_COLLECT: begin
                o_cmd.in_take = take;
                if (take && i_in_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.calc_check = 1'b1;
                n_state          = S_DIGIT;
            end
            S_DIGIT: begin
                o_cmd.calc_digits = 1'b1;
                n_state           = i_stat.too_long ? S_TL : S_SEMI;
            end
            S_TL: begin
                o_cmd.out_sel  = OSEL_TL;
                o_cmd.out_last = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.clr_msg  = 1'b1;
                    n_state        = S_COLLECT;
                end
            end
            S_SEMI: begin
                o_cmd.out_sel = OSEL_SEMI;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_TENS;
                end
            end
            S_TENS: begin
                o_cmd.out_sel = OSEL_TENS;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_ONES;
                end
            end
            S_ONES: begin
                // A zero confirm character ends the frame after the digits
                o_cmd.out_sel  = OSEL_ONES;
                o_cmd.out_last = i_stat.conf_zero;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_stat.conf_zero) begin
                        o_cmd.clr_msg = 1'b1;
                        n_state       = S_COLLECT;
                    end else begin
                        n_state = S_CONF;
                    end
                end
            end
            S_CONF: begin
                o_cmd.out_sel = OSEL_CONF;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                // Store read data lands at the end of this cycle
                n_state = S_PAY;
            end
            S_PAY: begin
                o_cmd.out_sel  = OSEL_PAY;
                o_cmd.out_last = i_stat.idx_at_end && !i_stat.add_nl;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (!i_stat.idx_at_end) begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_RD;
                    end else if (i_stat.add_nl) begin
                        n_state = S_NL;
                    end else begin
                        o_cmd.clr_msg = 1'b1;
                        n_state       = S_COLLECT;
                    end
                end
            end
            S_NL: begin
                o_cmd.out_sel  = OSEL_NL;
                o_cmd.out_last = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.clr_msg  = 1'b1;
                    n_state        = S_COLLECT;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> sim/clf_checker.sv
`timescale 1ns / 1ps

module clf_checker
    import clf_pkg::*;
#(
    parameter logic [2:0] CONFIRM_ADDR = 3'd0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
    input  wire logic        s_axis_tlast,   // payload_last
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
    input  wire logic        m_axis_tlast,   // frame_last
    input  wire logic        m_axis_tuser,   // [0] too_long
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
        logic       too_long;
    } t_frame_item;

    t_frame_item frame_expect_q[$];

    // Shadow of the message store and the confirm register
    logic [7:0]  msg_bytes [STORE_DEPTH];
    int unsigned msg_len;
    logic        msg_overflow;
    logic [7:0]  confirm_char;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int unsigned add_printable(int unsigned sum, logic [7:0] b);
        return (b >= CHAR_SPACE && b <= CHAR_MAXVIS) ? sum + b : sum;
    endfunction

    task automatic expect_frame_item(logic [7:0] b, logic last, logic rejected);
        t_frame_item item;
        item.frame_byte = b;
        item.frame_last = last;
        item.too_long   = rejected;
        frame_expect_q.push_back(item);
    endtask

    // Store one payload byte; on the last byte build the expected frame
    task automatic frame_on_byte(logic [7:0] b, logic last);
        int unsigned n;
        int unsigned sum;
        int unsigned check;
        logic        add_nl;
        logic        stop;
        if (msg_len < MAX_FRAME && msg_len < STORE_DEPTH) begin
            msg_bytes[msg_len] = b;
            msg_len++;
        end else begin
            msg_overflow = 1'b1;
        end
        if (!last)
            return;

        n       = msg_len;
        msg_len = 0;
        if (msg_overflow || n + 5 >= MAX_FRAME) begin
            msg_overflow = 1'b0;
            expect_frame_item(8'd0, 1'b1, 1'b1);
            return;
        end

        add_nl = (msg_bytes[n - 1] != CHAR_NEWLINE);
        // Sum runs from the confirm char and stops after the first newline
        sum = 0;
        if (confirm_char != 8'd0 && confirm_char != CHAR_NEWLINE) begin
            stop = 1'b0;
            sum  = add_printable(sum, confirm_char);
            for (int i = 0; i < n && !stop; i++) begin
                sum = add_printable(sum, msg_bytes[i]);
                if (msg_bytes[i] == CHAR_NEWLINE)
                    stop = 1'b1;
            end
        end
        check = (sum % CHECK_MOD) + 1;

        expect_frame_item(CHAR_SEMI, 1'b0, 1'b0);
        expect_frame_item(CHAR_ZERO + 8'(check / 10), 1'b0, 1'b0);
        // A zero confirm char cuts the frame after the digits
        if (confirm_char == 8'd0) begin
            expect_frame_item(CHAR_ZERO + 8'(check % 10), 1'b1, 1'b0);
            return;
        end
        expect_frame_item(CHAR_ZERO + 8'(check % 10), 1'b0, 1'b0);
        expect_frame_item(confirm_char, 1'b0, 1'b0);
        for (int i = 0; i < n; i++)
            expect_frame_item(msg_bytes[i], !add_nl && (i + 1 == n), 1'b0);
        if (add_nl)
            expect_frame_item(CHAR_NEWLINE, 1'b1, 1'b0);
    endtask

    // Compare outgoing items first, then predict from the incoming one
    always @(posedge i_clk) begin
        t_frame_item want;
        if (!i_rst_n) begin
            frame_expect_q.delete();
            msg_len      = 0;
            msg_overflow = 1'b0;
            confirm_char = CONFIRM_RESET;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (frame_expect_q.size() == 0) begin
                    $error("unexpected frame item: byte %0h last %0b too_long %0b",
                           m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    o_fail_count++;
                end else begin
                    want = frame_expect_q.pop_front();
                    if (m_axis_tdata !== want.frame_byte) begin
                        $error("frame_byte: expected %0h, got %0h",
                               want.frame_byte, m_axis_tdata);
                        o_fail_count++;
                    end
                    if (m_axis_tlast !== want.frame_last) begin
                        $error("frame_last: expected %0b, got %0b",
                               want.frame_last, m_axis_tlast);
                        o_fail_count++;
                    end
                    if (m_axis_tuser !== want.too_long) begin
                        $error("too_long: expected %0b, got %0b",
                               want.too_long, m_axis_tuser);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                frame_on_byte(s_axis_tdata, s_axis_tlast);
            if (psel && penable && pwrite && pready && paddr == CONFIRM_ADDR)
                confirm_char = pwdata[7:0];
        end
        o_pending = frame_expect_q.size();
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import clf_pkg::*;

    localparam logic [2:0] REG_CONFIRM   = 3'd0;
    localparam int         LIMIT_CYCLES  = 400000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         PHASE_BYTES   = 17;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] payload_byte
    logic        s_axis_tlast;   // payload_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;   // [7:0] frame_byte
    logic        m_axis_tlast;   // frame_last
    logic        m_axis_tuser;   // [0] too_long
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   bytes_sent;
    logic calm = 1'b0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    always #5 i_clk = ~i_clk;

    checksummed_line_framer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    clf_checker #(.CONFIRM_ADDR(REG_CONFIRM)) frame_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("checksummed_line_framer verification failed");
            $finish;
        end
    end

    // Frame sink: random stalls, one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 6);
        end
    end

    function automatic logic [7:0] pick_payload_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return CHAR_NEWLINE;
        if (r < 20)
            return 8'($urandom_range(31, 1));
        if (r < 35)
            return 8'($urandom_range(255, 128));
        return 8'($urandom_range(127, 32));
    endfunction

    // Offer one payload item and wait until it is taken
    task automatic send_byte(logic [7:0] b, logic last);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom);
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_message(int len, logic end_nl);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = pick_payload_byte();
            if (i == len - 1 && end_nl)
                b = CHAR_NEWLINE;
            send_byte(b, i == len - 1);
        end
    endtask

    // Drop valid and wait until every expected frame item is out
    task automatic drain_frames();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_confirm(logic [7:0] value);
        drain_frames();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CONFIRM;
        pwdata  <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int         len;
        logic [7:0] conf;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = REG_CONFIRM;
        pwdata        = 32'd0;
        bytes_sent    = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: short messages, byte extremes, early newline
        write_confirm(CONFIRM_RESET);
        send_byte("A", 1'b1);
        send_byte(CHAR_NEWLINE, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(CHAR_SPACE, 1'b0);
        send_byte(8'h1F, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte("x", 1'b1);
        send_byte("a", 1'b0);
        send_byte(CHAR_NEWLINE, 1'b0);
        send_byte("b", 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        // Directed: zero, newline and top-value confirm chars
        write_confirm(8'h00);
        send_byte("z", 1'b1);
        write_confirm(CHAR_NEWLINE);
        send_byte("q", 1'b1);
        write_confirm(8'hFF);
        send_byte("k", 1'b0);
        send_byte(CHAR_NEWLINE, 1'b1);

        // Random phases, each under its own confirm char
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                1:       conf = 8'h00;
                2:       conf = 8'hFF;
                3:       conf = CHAR_NEWLINE;
                4:       conf = 8'($urandom);
                default: conf = 8'($urandom_range(126, 32));
            endcase
            write_confirm(conf);
            calm    <= (ph == 4);
            hold_go <= (ph == 7);
            bytes_sent = 0;
            // Length boundaries: longest accepted, shortest rejected, overflow
            case (ph)
                5: send_message(MAX_FRAME - 6, 1'($urandom_range(1)));
                6: send_message(MAX_FRAME - 5, 1'($urandom_range(1)));
                7: begin
                    // Keep offering while the sink holds off so intake stalls
                    send_message(STORE_DEPTH + 1, 1'b0);
                    repeat (2) send_message(8, 1'b0);
                end
                default: ;
            endcase
            while (bytes_sent < PHASE_BYTES) begin
                len = $urandom_range(99);
                if (len < 70)
                    len = $urandom_range(12, 1);
                else if (len < 95)
                    len = $urandom_range(40, 13);
                else
                    len = $urandom_range(70, 41);
                send_message(len, $urandom_range(3) == 0);
            end
        end

        drain_frames();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("checksummed_line_framer verification clean");
        else
            $display("checksummed_line_framer verification failed");
        $finish;
    end

endmodule

>>> files.f
src/clf_pkg.sv
src/clf_datapath.sv
src/clf_ctrl.sv
src/checksummed_line_framer.sv
sim/clf_checker.sv
sim/tb.sv
